>>> rtl/core/arm_ik_pkg.sv
`timescale 1ns / 1ps

package arm_ik_pkg;

    // Default build parameters
    localparam int COORD_WIDTH   = 16;
    localparam int CORDIC_STAGES = 16;

    // Configuration registers
    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_W-1:0] CFG_RESET = 15'd819;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_HEIGHT = 2'd0,
        REG_UPPER_LINK  = 2'd1,
        REG_LOWER_LINK  = 2'd2
    } cfg_reg_t;

    // Datapath widths
    localparam int VEC_W  = 49;   // signed vector components entering the CORDIC
    localparam int ZW     = 24;   // Q20 angle accumulator
    localparam int ROOT_W = 31;   // root of the 62-bit sine radicand
    localparam int XC_W   = 17;   // clamped coordinate after the coarse reach test
    localparam int NUM_W  = 32;   // clamped cosine-law numerator

    localparam logic signed [ZW-1:0] PI_Q20 = 24'sd3294198;

    // Output angle limits, Q12 radians
    localparam int SH_MIN = -25736;
    localparam int SH_MAX = 12868;
    localparam int EL_MAX = 12868;

    // Sideband carried through the square root pipeline
    typedef struct packed {
        logic [15:0]             y16;
        logic                    far;
        logic signed [XC_W-1:0]  dzc;
        logic signed [XC_W-1:0]  xc;
        logic signed [NUM_W-1:0] numc;
    } sq_side_t;

    // Sideband carried through the CORDIC pipeline
    typedef struct packed {
        logic [15:0] y16;
        logic        far;
    } cd_side_t;

    // Arctangent of 2^-i in Q20 radians
    function automatic logic signed [ZW-1:0] atan_q20(input int i);
        logic signed [ZW-1:0] a;
        case (i)
            0:       a = 24'sd823550;
            1:       a = 24'sd486170;
            2:       a = 24'sd256879;
            3:       a = 24'sd130396;
            4:       a = 24'sd65451;
            5:       a = 24'sd32757;
            6:       a = 24'sd16383;
            7:       a = 24'sd8192;
            8:       a = 24'sd4096;
            9:       a = 24'sd2048;
            10:      a = 24'sd1024;
            11:      a = 24'sd512;
            12:      a = 24'sd256;
            13:      a = 24'sd128;
            14:      a = 24'sd64;
            15:      a = 24'sd32;
            16:      a = 24'sd16;
            17:      a = 24'sd8;
            18:      a = 24'sd4;
            19:      a = 24'sd2;
            20:      a = 24'sd1;
            default: a = 24'sd0;
        endcase
        return a;
    endfunction

endpackage

>>> rtl/core/arm_ik_isqrt.sv
`timescale 1ns / 1ps

module arm_ik_isqrt #(
    parameter int RW     = arm_ik_pkg::ROOT_W,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [2*RW-1:0]   in_rad,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [RW-1:0]     out_root,
    output logic [SIDE_W-1:0] out_side
);

    localparam int REMW = RW + 3;

    logic [REMW-1:0]   rem_reg  [RW];
    logic [RW-1:0]     q_reg    [RW];
    logic [2*RW-1:0]   rad_reg  [RW];
    logic              v_reg    [RW];
    logic [SIDE_W-1:0] side_reg [RW];

    // One root bit per stage, two radicand bits brought down each time
    for (genvar j = 0; j < RW; j++) begin : g_stage
        logic [REMW-1:0]   rem_in;
        logic [RW-1:0]     q_in;
        logic [2*RW-1:0]   rad_in;
        logic              v_in;
        logic [SIDE_W-1:0] side_in;
        logic [REMW-1:0]   cur;
        logic [REMW-1:0]   trial;
        logic              ge;

        if (j == 0) begin : g_first
            assign rem_in  = '0;
            assign q_in    = '0;
            assign rad_in  = in_rad;
            assign v_in    = in_valid;
            assign side_in = in_side;
        end else begin : g_next
            assign rem_in  = rem_reg[j-1];
            assign q_in    = q_reg[j-1];
            assign rad_in  = rad_reg[j-1];
            assign v_in    = v_reg[j-1];
            assign side_in = side_reg[j-1];
        end

        assign cur   = {rem_in[REMW-3:0], rad_in[2*RW-1 -: 2]};
        assign trial = REMW'({q_in, 2'b01});
        assign ge    = (cur >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (en) begin
                v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[j]    <= {q_in[RW-2:0], ge};
                side_reg[j] <= side_in;
            end
        end

        // Remainder and radicand are not needed past the last stage
        if (j < RW - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[j] <= ge ? (cur - trial) : cur;
                    rad_reg[j] <= {rad_in[2*RW-3:0], 2'b00};
                end
            end
        end
    end

    assign out_valid = v_reg[RW-1];
    assign out_root  = q_reg[RW-1];
    assign out_side  = side_reg[RW-1];

endmodule

>>> rtl/core/arm_ik_cordic.sv
`timescale 1ns / 1ps

module arm_ik_cordic #(
    parameter int STAGES = arm_ik_pkg::CORDIC_STAGES,
    parameter int LANES  = 3,
    parameter int SIDE_W = 1
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [arm_ik_pkg::VEC_W-1:0] in_y [LANES],
    input  logic signed [arm_ik_pkg::VEC_W-1:0] in_x [LANES],
    input  logic [SIDE_W-1:0]                 in_side,
    output logic                              out_valid,
    output logic signed [arm_ik_pkg::ZW-1:0]  out_z [LANES],
    output logic [SIDE_W-1:0]                 out_side
);

    localparam int NRM = 6;                        // normalize shifts 32,16,8,4,2,1
    localparam int TOT = 1 + NRM + STAGES;
    localparam int IW  = arm_ik_pkg::VEC_W + 2;    // headroom for CORDIC gain
    localparam int MW  = arm_ik_pkg::VEC_W - 1;    // magnitude width
    localparam int ZW  = arm_ik_pkg::ZW;

    logic signed [IW-1:0] x_reg    [TOT][LANES];
    logic signed [IW-1:0] y_reg    [TOT][LANES];
    logic signed [ZW-1:0] z_reg    [TOT][LANES];
    logic                 zero_reg [TOT][LANES];
    logic [MW-1:0]        m_reg    [NRM][LANES];
    logic                 v_reg    [TOT];
    logic [SIDE_W-1:0]    side_reg [TOT];

    for (genvar j = 0; j < TOT; j++) begin : g_stage
        // Advance valid and sideband
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (en) begin
                v_reg[j] <= (j == 0) ? in_valid : v_reg[(j == 0) ? 0 : j-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[j] <= (j == 0) ? in_side : side_reg[(j == 0) ? 0 : j-1];
            end
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            if (j == 0) begin : g_pre
                // Fold the left half plane onto the right, start at plus or minus pi
                logic signed [IW-1:0] xe;
                logic signed [IW-1:0] ye;
                logic [MW-1:0]        ay;
                logic signed [ZW-1:0] z0;

                always_comb begin
                    xe = IW'(in_x[l]);
                    ye = IW'(in_y[l]);
                    z0 = '0;
                    if (in_x[l] < 0) begin
                        xe = -xe;
                        ye = -ye;
                        z0 = (in_y[l] >= 0) ? arm_ik_pkg::PI_Q20 : -arm_ik_pkg::PI_Q20;
                    end
                    ay = (ye < 0) ? MW'(-ye) : MW'(ye);
                end

                always_ff @(posedge aclk) begin
                    if (en) begin
                        x_reg[j][l]    <= xe;
                        y_reg[j][l]    <= ye;
                        z_reg[j][l]    <= z0;
                        m_reg[j][l]    <= MW'(xe) | ay;
                        zero_reg[j][l] <= (in_x[l] == 0) && (in_y[l] == 0);
                    end
                end
            end else if (j <= NRM) begin : g_norm
                // Scale up by a power of two while the larger magnitude stays below 2^(MW-1)
                localparam int S = 32 >> (j - 1);
                logic shift;

                assign shift = ((m_reg[j-1][l] >> (MW - 1 - S)) == '0);

                always_ff @(posedge aclk) begin
                    if (en) begin
                        x_reg[j][l]    <= shift ? (x_reg[j-1][l] <<< S) : x_reg[j-1][l];
                        y_reg[j][l]    <= shift ? (y_reg[j-1][l] <<< S) : y_reg[j-1][l];
                        z_reg[j][l]    <= z_reg[j-1][l];
                        zero_reg[j][l] <= zero_reg[j-1][l];
                    end
                end

                if (j < NRM) begin : g_mag
                    always_ff @(posedge aclk) begin
                        if (en) begin
                            m_reg[j][l] <= shift ? (m_reg[j-1][l] << S) : m_reg[j-1][l];
                        end
                    end
                end
            end else begin : g_rot
                // Rotate toward the x axis and accumulate the angle
                localparam int I = j - 1 - NRM;
                localparam logic signed [ZW-1:0] A = arm_ik_pkg::atan_q20(I);
                logic signed [IW-1:0] xs;
                logic signed [IW-1:0] ys;

                assign xs = x_reg[j-1][l] >>> I;
                assign ys = y_reg[j-1][l] >>> I;

                always_ff @(posedge aclk) begin
                    if (en) begin
                        if (y_reg[j-1][l] >= 0) begin
                            x_reg[j][l] <= x_reg[j-1][l] + ys;
                            y_reg[j][l] <= y_reg[j-1][l] - xs;
                            z_reg[j][l] <= z_reg[j-1][l] + A;
                        end else begin
                            x_reg[j][l] <= x_reg[j-1][l] - ys;
                            y_reg[j][l] <= y_reg[j-1][l] + xs;
                            z_reg[j][l] <= z_reg[j-1][l] - A;
                        end
                        zero_reg[j][l] <= zero_reg[j-1][l];
                    end
                end
            end
        end
    end

    // Zero vector gives angle zero
    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign out_z[l] = zero_reg[TOT-1][l] ? '0 : z_reg[TOT-1][l];
    end

    assign out_valid = v_reg[TOT-1];
    assign out_side  = side_reg[TOT-1];

endmodule

>>> rtl/core/arm_inverse_kinematics.sv
`timescale 1ns / 1ps

// Inverse kinematics for a prismatic base joint and two revolute links. Each
// item is a target (x, y, z) in signed Q4.12 metres; each result gives the
// prismatic position (y), the shoulder and elbow angles in Q12 radians, and an
// out-of-reach flag in m_tuser that forces both angles to zero. The block takes
// one item per clock and returns results in order. It has nine stages of reach
// test and cosine-law arithmetic, a 31-stage square root that yields one root
// bit per stage, two product and sum stages, a three-lane vectoring CORDIC with
// seven fold and normalize stages ahead of its rotation stages, and two stages
// of angle difference and rounding. The whole pipeline holds while a result
// waits at the output. The user must write link registers through the plain
// write port only while no item is in flight; the block does not enforce this.
module arm_inverse_kinematics #(
    parameter int COORD_WIDTH   = arm_ik_pkg::COORD_WIDTH,
    parameter int CORDIC_STAGES = arm_ik_pkg::CORDIC_STAGES
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration write port
    input  logic                             cfg_we,
    input  logic [arm_ik_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [arm_ik_pkg::CFG_W-1:0]     cfg_wdata,
    // Target items
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // x, y, z coordinates (COORD_WIDTH each), zero fill
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    // Joint results
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // prismatic_pos[15:0], shoulder_angle[31:16], elbow_angle[45:32], zero fill
    output logic [47:0]                      m_tdata,
    // out_of_reach
    output logic [0:0]                       m_tuser
);

    localparam int CW    = COORD_WIDTH;
    localparam int CMPW  = (CW + 3 > 18) ? CW + 3 : 18;
    localparam int CFG_W = arm_ik_pkg::CFG_W;
    localparam int VEC_W = arm_ik_pkg::VEC_W;
    localparam int ZW    = arm_ik_pkg::ZW;
    localparam int RW    = arm_ik_pkg::ROOT_W;
    localparam int XC_W  = arm_ik_pkg::XC_W;
    localparam int NUM_W = arm_ik_pkg::NUM_W;

    // ------------------------------------------------------------------
    // Configuration registers
    logic [CFG_W-1:0] base_height_reg;
    logic [CFG_W-1:0] upper_link_reg;
    logic [CFG_W-1:0] lower_link_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_height_reg <= arm_ik_pkg::CFG_RESET;
            upper_link_reg  <= arm_ik_pkg::CFG_RESET;
            lower_link_reg  <= arm_ik_pkg::CFG_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                arm_ik_pkg::REG_BASE_HEIGHT: base_height_reg <= cfg_wdata;
                arm_ik_pkg::REG_UPPER_LINK:  upper_link_reg  <= cfg_wdata;
                arm_ik_pkg::REG_LOWER_LINK:  lower_link_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Link-derived constants, refreshed every cycle
    logic [15:0] reach;
    logic [29:0] l2sq_reg;
    logic [29:0] l3sq_reg;
    logic [30:0] den_reg;
    logic [31:0] rsq_reg;
    logic [30:0] sumsq_reg;

    assign reach = 16'(upper_link_reg) + 16'(lower_link_reg);

    always_ff @(posedge aclk) begin
        l2sq_reg  <= 30'(upper_link_reg) * 30'(upper_link_reg);
        l3sq_reg  <= 30'(lower_link_reg) * 30'(lower_link_reg);
        den_reg   <= {30'(upper_link_reg) * 30'(lower_link_reg), 1'b0};
        rsq_reg   <= 32'(reach) * 32'(reach);
        sumsq_reg <= 31'(l2sq_reg) + 31'(l3sq_reg);
    end

    // ------------------------------------------------------------------
    // Pipeline advance: the whole pipe moves unless a result is held
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    logic signed [CW-1:0] in_x;
    logic signed [CW-1:0] in_y;
    logic signed [CW-1:0] in_z;
    assign in_x = s_tdata[CW-1:0];
    assign in_y = s_tdata[2*CW-1:CW];
    assign in_z = s_tdata[3*CW-1:2*CW];

    // Stage 1: plane offset
    logic                   v1_reg;
    logic signed [CMPW-1:0] x1_reg;
    logic signed [CMPW-1:0] dz1_reg;
    logic [15:0]            y16_1_reg;
    logic signed [CMPW-1:0] y_ext;

    assign y_ext = CMPW'(in_y);

    always_ff @(posedge aclk) begin
        if (adv) begin
            x1_reg    <= CMPW'(in_x);
            dz1_reg   <= CMPW'(in_z) - y_ext - $signed(CMPW'(base_height_reg));
            y16_1_reg <= y_ext[15:0];
        end
    end

    // Stage 2: coarse reach test, clamp coordinates for squaring
    logic                   v2_reg;
    logic                   far2_reg;
    logic signed [XC_W-1:0] xc2_reg;
    logic signed [XC_W-1:0] dzc2_reg;
    logic [15:0]            y16_2_reg;
    logic [CMPW-1:0]        ax1;
    logic [CMPW-1:0]        adz1;
    logic                   far_coarse;

    assign ax1        = (x1_reg < 0) ? CMPW'(-x1_reg) : CMPW'(x1_reg);
    assign adz1       = (dz1_reg < 0) ? CMPW'(-dz1_reg) : CMPW'(dz1_reg);
    assign far_coarse = (ax1 > CMPW'(reach)) || (adz1 > CMPW'(reach));

    always_ff @(posedge aclk) begin
        if (adv) begin
            far2_reg  <= far_coarse;
            xc2_reg   <= far_coarse ? '0 : x1_reg[XC_W-1:0];
            dzc2_reg  <= far_coarse ? '0 : dz1_reg[XC_W-1:0];
            y16_2_reg <= y16_1_reg;
        end
    end

    // Stage 3: squares
    logic                   v3_reg;
    logic                   far3_reg;
    logic [32:0]            xsq3_reg;
    logic [32:0]            dzsq3_reg;
    logic signed [XC_W-1:0] xc3_reg;
    logic signed [XC_W-1:0] dzc3_reg;
    logic [15:0]            y16_3_reg;
    logic signed [33:0]     xsq_full;
    logic signed [33:0]     dzsq_full;

    assign xsq_full  = xc2_reg * xc2_reg;
    assign dzsq_full = dzc2_reg * dzc2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            far3_reg  <= far2_reg;
            xsq3_reg  <= xsq_full[32:0];
            dzsq3_reg <= dzsq_full[32:0];
            xc3_reg   <= xc2_reg;
            dzc3_reg  <= dzc2_reg;
            y16_3_reg <= y16_2_reg;
        end
    end

    // Stage 4: squared distance
    logic                   v4_reg;
    logic                   far4_reg;
    logic [33:0]            d2_4_reg;
    logic signed [XC_W-1:0] xc4_reg;
    logic signed [XC_W-1:0] dzc4_reg;
    logic [15:0]            y16_4_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            far4_reg  <= far3_reg;
            d2_4_reg  <= 34'(xsq3_reg) + 34'(dzsq3_reg);
            xc4_reg   <= xc3_reg;
            dzc4_reg  <= dzc3_reg;
            y16_4_reg <= y16_3_reg;
        end
    end

    // Stage 5: fine reach test, cosine-law numerator
    logic                   v5_reg;
    logic                   far5_reg;
    logic signed [35:0]     num5_reg;
    logic signed [XC_W-1:0] xc5_reg;
    logic signed [XC_W-1:0] dzc5_reg;
    logic [15:0]            y16_5_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            far5_reg  <= far4_reg || (d2_4_reg > 34'(rsq_reg));
            num5_reg  <= $signed(36'(d2_4_reg)) - $signed(36'(sumsq_reg));
            xc5_reg   <= xc4_reg;
            dzc5_reg  <= dzc4_reg;
            y16_5_reg <= y16_4_reg;
        end
    end

    // Stage 6: clamp numerator to plus or minus the denominator
    logic                    v6_reg;
    logic                    far6_reg;
    logic signed [NUM_W-1:0] numc6_reg;
    logic signed [XC_W-1:0]  xc6_reg;
    logic signed [XC_W-1:0]  dzc6_reg;
    logic [15:0]             y16_6_reg;
    logic signed [35:0]      den36;
    logic signed [35:0]      numc_next;

    assign den36 = $signed(36'(den_reg));

    always_comb begin
        if (num5_reg > den36) begin
            numc_next = den36;
        end else if (num5_reg < -den36) begin
            numc_next = -den36;
        end else begin
            numc_next = num5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            far6_reg  <= far5_reg;
            numc6_reg <= numc_next[NUM_W-1:0];
            xc6_reg   <= xc5_reg;
            dzc6_reg  <= dzc5_reg;
            y16_6_reg <= y16_5_reg;
        end
    end

    // Stage 7: numerator magnitude
    logic                    v7_reg;
    logic                    far7_reg;
    logic [30:0]             numabs7_reg;
    logic signed [NUM_W-1:0] numc7_reg;
    logic signed [XC_W-1:0]  xc7_reg;
    logic signed [XC_W-1:0]  dzc7_reg;
    logic [15:0]             y16_7_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            far7_reg    <= far6_reg;
            numabs7_reg <= (numc6_reg < 0) ? 31'(-numc6_reg) : 31'(numc6_reg);
            numc7_reg   <= numc6_reg;
            xc7_reg     <= xc6_reg;
            dzc7_reg    <= dzc6_reg;
            y16_7_reg   <= y16_6_reg;
        end
    end

    // Stage 8: squares of denominator and numerator
    logic                    v8_reg;
    logic                    far8_reg;
    logic [61:0]             densq8_reg;
    logic [61:0]             numsq8_reg;
    logic signed [NUM_W-1:0] numc8_reg;
    logic signed [XC_W-1:0]  xc8_reg;
    logic signed [XC_W-1:0]  dzc8_reg;
    logic [15:0]             y16_8_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            far8_reg   <= far7_reg;
            densq8_reg <= 62'(den_reg) * 62'(den_reg);
            numsq8_reg <= 62'(numabs7_reg) * 62'(numabs7_reg);
            numc8_reg  <= numc7_reg;
            xc8_reg    <= xc7_reg;
            dzc8_reg   <= dzc7_reg;
            y16_8_reg  <= y16_7_reg;
        end
    end

    // Stage 9: sine radicand
    logic                 v9_reg;
    logic [61:0]          rad9_reg;
    arm_ik_pkg::sq_side_t side9_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            rad9_reg       <= densq8_reg - numsq8_reg;
            side9_reg.y16  <= y16_8_reg;
            side9_reg.far  <= far8_reg;
            side9_reg.dzc  <= dzc8_reg;
            side9_reg.xc   <= xc8_reg;
            side9_reg.numc <= numc8_reg;
        end
    end

    // Valid chain for the front stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
            v9_reg <= v8_reg;
        end
    end

    // ------------------------------------------------------------------
    // Square root of the radicand gives the scaled sine
    logic                 sq_valid;
    logic [RW-1:0]        sq_root;
    arm_ik_pkg::sq_side_t sq_side;

    arm_ik_isqrt #(
        .RW     (RW),
        .SIDE_W ($bits(arm_ik_pkg::sq_side_t))
    ) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v9_reg),
        .in_rad    (rad9_reg),
        .in_side   (side9_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // P1: products for the shoulder correction vector
    logic                    vp1_reg;
    logic [45:0]             ls_reg;
    logic [45:0]             ld_reg;
    logic signed [47:0]      ln_reg;
    logic [RW-1:0]           s_p1_reg;
    arm_ik_pkg::sq_side_t    side_p1_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            ls_reg      <= 46'(lower_link_reg) * 46'(sq_root);
            ld_reg      <= 46'(upper_link_reg) * 46'(den_reg);
            ln_reg      <= $signed({1'b0, lower_link_reg}) * sq_side.numc;
            s_p1_reg    <= sq_root;
            side_p1_reg <= sq_side;
        end
    end

    // P2: shoulder correction x component
    logic                    vp2_reg;
    logic signed [VEC_W-1:0] bx_reg;
    logic [45:0]             ls_p2_reg;
    logic [RW-1:0]           s_p2_reg;
    arm_ik_pkg::sq_side_t    side_p2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            bx_reg      <= $signed(VEC_W'(ld_reg)) + VEC_W'(ln_reg);
            ls_p2_reg   <= ls_reg;
            s_p2_reg    <= s_p1_reg;
            side_p2_reg <= side_p1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp1_reg <= 1'b0;
            vp2_reg <= 1'b0;
        end else if (adv) begin
            vp1_reg <= sq_valid;
            vp2_reg <= vp1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Three angles: elbow, shoulder correction, target direction
    logic signed [VEC_W-1:0] cd_y [3];
    logic signed [VEC_W-1:0] cd_x [3];
    logic signed [ZW-1:0]    cd_z [3];
    arm_ik_pkg::cd_side_t    cd_side_in;
    arm_ik_pkg::cd_side_t    cd_side;
    logic                    cd_valid;

    assign cd_y[0] = $signed(VEC_W'(s_p2_reg));
    assign cd_x[0] = VEC_W'(side_p2_reg.numc);
    assign cd_y[1] = $signed(VEC_W'(ls_p2_reg));
    assign cd_x[1] = bx_reg;
    assign cd_y[2] = VEC_W'(side_p2_reg.dzc);
    assign cd_x[2] = VEC_W'(side_p2_reg.xc);

    assign cd_side_in.y16 = side_p2_reg.y16;
    assign cd_side_in.far = side_p2_reg.far;

    arm_ik_cordic #(
        .STAGES (CORDIC_STAGES),
        .LANES  (3),
        .SIDE_W ($bits(arm_ik_pkg::cd_side_t))
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (vp2_reg),
        .in_y      (cd_y),
        .in_x      (cd_x),
        .in_side   (cd_side_in),
        .out_valid (cd_valid),
        .out_z     (cd_z),
        .out_side  (cd_side)
    );

    // R1: shoulder difference
    logic                   vr1_reg;
    logic signed [ZW:0]     sh_r1_reg;
    logic signed [ZW-1:0]   el_r1_reg;
    arm_ik_pkg::cd_side_t   side_r1_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            sh_r1_reg   <= (ZW+1)'(cd_z[2]) - (ZW+1)'(cd_z[1]);
            el_r1_reg   <= cd_z[0];
            side_r1_reg <= cd_side;
        end
    end

    // R2: round to Q12, clamp, zero when out of reach
    logic signed [ZW:0]   sh_q12;
    logic signed [ZW-1:0] el_q12;
    logic signed [15:0]   sh_next;
    logic [13:0]          el_next;

    assign sh_q12 = (sh_r1_reg + (ZW+1)'(128)) >>> 8;
    assign el_q12 = (el_r1_reg + ZW'(128)) >>> 8;

    always_comb begin
        if (side_r1_reg.far) begin
            sh_next = '0;
        end else if (sh_q12 < (ZW+1)'(arm_ik_pkg::SH_MIN)) begin
            sh_next = 16'(arm_ik_pkg::SH_MIN);
        end else if (sh_q12 > (ZW+1)'(arm_ik_pkg::SH_MAX)) begin
            sh_next = 16'(arm_ik_pkg::SH_MAX);
        end else begin
            sh_next = sh_q12[15:0];
        end

        if (side_r1_reg.far || el_q12 < 0) begin
            el_next = '0;
        end else if (el_q12 > ZW'(arm_ik_pkg::EL_MAX)) begin
            el_next = 14'(arm_ik_pkg::EL_MAX);
        end else begin
            el_next = el_q12[13:0];
        end
    end

    // Output register
    logic               out_valid_reg;
    logic [15:0]        pos_out_reg;
    logic signed [15:0] sh_out_reg;
    logic [13:0]        el_out_reg;
    logic               far_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vr1_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            vr1_reg       <= cd_valid;
            out_valid_reg <= vr1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pos_out_reg <= side_r1_reg.y16;
            sh_out_reg  <= sh_next;
            el_out_reg  <= el_next;
            far_out_reg <= side_r1_reg.far;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, el_out_reg, sh_out_reg, pos_out_reg};
    assign m_tuser  = far_out_reg;

`ifndef SYNTHESIS
    // Input side moves exactly when the output side does not hold a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    // Out of reach forces both angles to zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[45:16] == '0))
        else $error("angles not zero on out-of-reach result");

    // Elbow stays within zero to pi
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[45:32] <= 14'(arm_ik_pkg::EL_MAX)))
        else $error("elbow angle above pi");

    // A stalled pipeline keeps its result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("held result changed");
`endif

endmodule

>>> dv/ik_checker.sv
`timescale 1ns / 1ps

module ik_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic [0:0]  m_tuser,
    output int          fail_count,
    output int          pending,
    output int          far_count,
    output int          near_count
);
    import arm_ik_pkg::*;

    typedef struct packed {
        logic [15:0] prismatic;
        logic [15:0] shoulder;
        logic [13:0] elbow;
        logic        far;
    } joints_t;

    localparam longint HALF_TURN_Q20 = 64'sd3294198;

    longint base_h, link_up, link_lo;
    joints_t joint_q[$];

    assign pending = joint_q.size();

    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint absv(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint root64(longint unsigned v);
        longint unsigned res, bit_w;
        res = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w >>= 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v -= res + bit_w;
                res = (res >> 1) + bit_w;
            end else begin
                res >>= 1;
            end
            bit_w >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint atan_tab(int i);
        longint t[21] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                          4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};
        return (i < 21) ? t[i] : 0;
    endfunction

    // Vectoring rotation: angle of (x, y) in Q20 radians
    function automatic longint vec_angle(longint y, longint x);
        longint z, xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? HALF_TURN_Q20 : -HALF_TURN_Q20;
            x = -x;
            y = -y;
        end
        while (absv(x) < (64'sd1 << 46) && absv(y) < (64'sd1 << 46)) begin
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
            xs = fshr(x, i);
            ys = fshr(y, i);
            if (y >= 0) begin
                x += ys; y -= xs; z += atan_tab(i);
            end else begin
                x -= ys; y += xs; z -= atan_tab(i);
            end
        end
        return z;
    endfunction

    function automatic longint round_q12(longint q20, longint lo, longint hi);
        longint r;
        r = fshr(q20 + 128, 8);
        if (r < lo) r = lo;
        if (r > hi) r = hi;
        return r;
    endfunction

    function automatic joints_t solve_joints(logic [47:0] item);
        joints_t j;
        longint x, y, z, dz, reach, d2, den, num, s, el, sh;
        logic far;
        x = longint'($signed(item[15:0]));
        y = longint'($signed(item[31:16]));
        z = longint'($signed(item[47:32]));
        dz = z - (y + base_h);
        reach = link_up + link_lo;
        far = 0;
        d2 = 0;
        j.prismatic = item[31:16];
        if (absv(x) > reach || absv(dz) > reach) far = 1;
        else begin
            d2 = x * x + dz * dz;
            if (d2 > reach * reach) far = 1;
        end
        j.far = far;
        j.shoulder = '0;
        j.elbow = '0;
        if (!far) begin
            den = 2 * link_up * link_lo;
            num = d2 - link_up * link_up - link_lo * link_lo;
            if (num > den) num = den;
            if (num < -den) num = -den;
            s = root64(longint'(longint'(den * den) - num * num));
            el = vec_angle(s, num);
            sh = vec_angle(dz, x) - vec_angle(link_lo * s, link_up * den + link_lo * num);
            j.shoulder = 16'(round_q12(sh, SH_MIN, SH_MAX));
            j.elbow = 14'(round_q12(el, 0, EL_MAX));
        end
        return j;
    endfunction

    always @(posedge aclk) begin
        joints_t exp_j;
        if (!aresetn) begin
            base_h <= 819;
            link_up <= 819;
            link_lo <= 819;
            fail_count <= 0;
            far_count <= 0;
            near_count <= 0;
            joint_q.delete();
        end else begin
            // track register writes
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    REG_BASE_HEIGHT: base_h <= cfg_wdata;
                    REG_UPPER_LINK:  link_up <= cfg_wdata;
                    REG_LOWER_LINK:  link_lo <= cfg_wdata;
                    default: ;
                endcase
            end
            // predict on accepted targets
            if (s_tvalid && s_tready) joint_q.push_back(solve_joints(s_tdata));
            // compare accepted results
            if (m_tvalid && m_tready) begin
                if (joint_q.size() == 0) begin
                    $display("%0t: unexpected result %h/%b", $time, m_tdata, m_tuser);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_j = joint_q.pop_front();
                    if (exp_j.far) far_count <= far_count + 1;
                    else near_count <= near_count + 1;
                    if (m_tdata[15:0] !== exp_j.prismatic || m_tdata[31:16] !== exp_j.shoulder
                        || m_tdata[45:32] !== exp_j.elbow || m_tuser[0] !== exp_j.far) begin
                        $display("%0t: expected pos %h sh %h el %h far %b, got %h %h %h %b",
                                 $time, exp_j.prismatic, exp_j.shoulder, exp_j.elbow,
                                 exp_j.far, m_tdata[15:0], m_tdata[31:16], m_tdata[45:32],
                                 m_tuser[0]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import arm_ik_pkg::*;

    localparam int LATENCY = 67;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [1:0]  cfg_index = '0;
    logic [14:0] cfg_wdata = '0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [47:0] m_tdata;
    logic [0:0]  m_tuser;
    int fail_count, pending, far_count, near_count;
    bit hold_off = 0;
    bit rx_on = 0;
    logic [14:0] lnk_up, lnk_lo, bh;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    arm_inverse_kinematics dut (.*);

    ik_checker chk (.*);

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        int g;
        wait (rx_on);
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_tready <= 0;
                repeat (300) @(posedge aclk);
                hold_off = 0;
            end
            g = gap_len();
            if (g == 0 || $urandom_range(0, 3) == 0) m_tready <= 1;
            else begin
                m_tready <= 0;
                repeat (g) @(posedge aclk);
                m_tready <= 1;
            end
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [14:0] val);
        @(posedge aclk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 0;
    endtask

    task automatic set_arm(logic [14:0] b, logic [14:0] u, logic [14:0] l);
        s_tvalid <= 0;
        wait (pending == 0);
        repeat (LATENCY + 10) @(posedge aclk);
        write_reg(REG_BASE_HEIGHT, b);
        write_reg(REG_UPPER_LINK, u);
        write_reg(REG_LOWER_LINK, l);
        bh = b; lnk_up = u; lnk_lo = l;
    endtask

    // Offer one target and hold it until accepted; valid drops only on a gap
    task automatic send_target(logic signed [15:0] x, logic signed [15:0] y,
                               logic signed [15:0] z, bit pace);
        int g;
        g = pace ? gap_len() : 0;
        if (g > 0) begin
            s_tvalid <= 0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {z, y, x};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Target mostly within reach of the current arm
    task automatic send_reachable(bit pace);
        int r, xx, dz, yy, zz;
        r = int'(lnk_up) + int'(lnk_lo);
        xx = $urandom_range(0, 2 * r) - r;
        dz = $urandom_range(0, 2 * r) - r;
        yy = $signed(16'($urandom));
        zz = dz + yy + int'(bh);
        if (zz > 32767 || zz < -32768) begin
            yy = $urandom_range(0, 8000) - 4000;
            zz = dz + yy + int'(bh);
        end
        if (xx > 32767) xx = 32767;
        if (xx < -32768) xx = -32768;
        if (zz > 32767) zz = 32767;
        if (zz < -32768) zz = -32768;
        send_target(16'(xx), 16'(yy), 16'(zz), pace);
    endtask

    initial begin
        logic signed [15:0] ext[4] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
        bh = 819; lnk_up = 819; lnk_lo = 819;
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        rx_on = 1;

        // directed: field extremes, zero vector, edges of reach
        foreach (ext[i]) send_target(ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4], 0);
        send_target(0, 0, 819, 0);
        send_target(1638, 0, 819, 0);
        send_target(1639, 0, 819, 0);
        send_target(0, 0, 819 + 1638, 0);
        send_target(0, 0, 819 - 1638, 0);
        send_target(-1638, 0, 819, 0);
        send_target(-1000, 0, 0, 0);
        send_target(-1000, 0, 1638, 0);
        send_target(1158, 0, 819 + 1158, 0);
        send_target(16'sh5555, 16'shaaaa, 16'sh5555, 0);
        send_target(16'shaaaa, 16'sh5555, 16'shaaaa, 0);

        // zero link length, then the extremes of the registers
        set_arm(1, 0, 819);
        send_target(100, 0, 1, 0);
        send_target(819, 0, 1, 0);
        set_arm(32767, 32767, 32767);
        send_target(-32768, -32768, 0, 0);
        send_target(32767, 0, 32767, 0);
        send_target(0, -32768, -32768, 0);
        set_arm(1, 1, 1);
        send_target(1, 0, 1, 0);
        send_target(0, 0, 2, 0);
        send_target(0, 0, 3, 0);

        // random phases with various arm geometries
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_arm(819, 819, 819);
                1: set_arm(32767, 16384, 16383);
                2: set_arm(1, 1, 32767);
                3: set_arm(15'($urandom), 15'($urandom_range(1, 2000)), 15'($urandom_range(1, 2000)));
                default: set_arm(15'($urandom_range(1, 32767)), 15'($urandom_range(1, 32767)),
                                 15'($urandom_range(1, 32767)));
            endcase
            if (ph == 1) hold_off = 1;
            for (int n = 0; n < 200; n++) begin
                if ($urandom_range(0, 4) == 0)
                    send_target(16'($urandom), 16'($urandom), 16'($urandom), ph != 1);
                else
                    send_reachable(ph != 1 && ph != 5);
            end
        end

        s_tvalid <= 0;
        wait (pending == 0);
        repeat (LATENCY + 20) @(posedge aclk);
        $display("Covered %0d reachable and %0d out-of-reach targets over 11 arm settings",
                 near_count, far_count);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end
endmodule
